[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/actr_pkg.sv]
// ----------------------------------------------------------------------------
// actr_pkg
// Types, constants and AES-128 round functions for the CTR keystream XOR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package actr_pkg;

	localparam int BLK_BYTES  = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 64;
	localparam int BLKNUM_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int LAST_ROUND = 10;
	localparam int RND_W      = 4;
	localparam int FQ_DEPTH   = 4;
	localparam int FQ_PTR_W   = 2;
	localparam int FQ_CNT_W   = 3;
	localparam int KSB_DEPTH  = 2;
	localparam int KSB_CNT_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_HIGH   = 3'd0,
		CFG_KEY_LOW    = 3'd1,
		CFG_NONCE_HIGH = 3'd2,
		CFG_NONCE_LOW  = 3'd3
	} cfg_idx_t;

	// one queued word between front and back
	typedef struct packed {
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] count;
	} item_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [RND_W-1:0] rnd);
		logic [7:0] r;
		case (rnd)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// next round key, bytes MSB first
	function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// SubBytes, ShiftRows, MixColumns (skipped on last round), AddRoundKey
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
		input logic last);
		logic [7:0]   b [BLK_BYTES];
		logic [7:0]   t [BLK_BYTES];
		logic [7:0]   a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int i = 0; i < BLK_BYTES; i++) begin
			b[i] = s[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[c*4+i] = SBOX[b[((c+i) & 3)*4+i]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4];
				a1 = t[c*4+1];
				a2 = t[c*4+2];
				a3 = t[c*4+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < BLK_BYTES; i++) begin
			r[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/actr_core.sv]
// ----------------------------------------------------------------------------
// actr_core
// Iterative AES-128 encryptor, one round per cycle, round keys on the fly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module actr_core
	import actr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         abort,
	input  wire logic         start,
	input  wire logic [127:0] key,
	input  wire logic [127:0] ctr_blk,
	output logic              busy,
	output logic              done,
	output logic [127:0]      ks_blk
);

	logic [127:0]     state_q;
	logic [127:0]     rk_q;
	logic [127:0]     rk_nxt;
	logic [RND_W-1:0] round_q;
	logic             busy_q;
	logic             done_q;
	logic             last;
	logic             launch;

	assign launch = start && !busy_q;
	assign last   = (round_q == RND_W'(LAST_ROUND));
	assign rk_nxt = key_step(rk_q, rcon(round_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else if (abort) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q  <= 1'b1;
				round_q <= RND_W'(1);
			end else if (busy_q) begin
				round_q <= round_q + RND_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			state_q <= ctr_blk ^ key;
			rk_q    <= key;
		end else if (busy_q) begin
			state_q <= aes_round(state_q, rk_nxt, last);
			rk_q    <= rk_nxt;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign ks_blk = state_q;

	`ASSERT_IMPLY(a_done_after_last, done_q, $past(round_q) == RND_W'(LAST_ROUND), "done without last round")

endmodule

`default_nettype wire

[hdl/actr_front.sv]
// ----------------------------------------------------------------------------
// actr_front
// Accepts data words, tags them with stream position, queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module actr_front
	import actr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       restart,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	output logic            q_valid,
	output item_t           q_item,
	input  wire logic       q_pop
);

	item_t               fq_mem [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q;
	logic [FQ_PTR_W-1:0] rd_ptr_q;
	logic [FQ_CNT_W-1:0] fill_q;
	logic [CNT_W-1:0]    pos_q;
	logic                push;

	assign in_ready = (fill_q != FQ_CNT_W'(FQ_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != '0);
	assign q_item   = fq_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
		end else if (restart) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FQ_PTR_W'(1);
				pos_q    <= pos_q + CNT_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + FQ_PTR_W'(1);
			end
			fill_q <= fill_q + FQ_CNT_W'(push) - FQ_CNT_W'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fq_mem[wr_ptr_q] <= '{data_byte: data_byte, idx: pos_q[IDX_W-1:0],
				count: pos_q + CNT_W'(1)};
		end
	end

endmodule

`default_nettype wire

[hdl/actr_back.sv]
// ----------------------------------------------------------------------------
// actr_back
// Keystream block generation ahead of use, XOR and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module actr_back
	import actr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         restart,
	input  wire logic [127:0] key,
	input  wire logic [95:0]  nonce,
	input  wire logic         q_valid,
	input  wire item_t        q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        out_byte,
	output logic [CNT_W-1:0]  byte_count
);

	logic [127:0]          ks_buf_q [KSB_DEPTH];
	logic                  ks_wr_q;
	logic                  ks_rd_q;
	logic [KSB_CNT_W-1:0]  blk_cnt_q;
	logic [BLKNUM_W-1:0]   blk_num_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  core_busy;
	logic                  core_done;
	logic [127:0]          core_blk;
	logic                  launch;
	logic                  blk_pop;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic [CNT_W-1:0]      byte_count_q;
	logic [127:0]          ks_cur;

	// keep at most two blocks buffered or in flight
	assign launch  = !core_busy && !core_done && (blk_cnt_q != KSB_CNT_W'(KSB_DEPTH));
	assign q_pop   = q_valid && (blk_cnt_q != '0) && (!out_valid_q || out_ready);
	assign blk_pop = q_pop && (rd_idx_q == IDX_W'(BLK_BYTES - 1));
	assign ks_cur  = ks_buf_q[ks_rd_q];

	actr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.abort   (restart),
		.start   (launch),
		.key     (key),
		.ctr_blk ({nonce, blk_num_q}),
		.busy    (core_busy),
		.done    (core_done),
		.ks_blk  (core_blk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_wr_q     <= 1'b0;
			ks_rd_q     <= 1'b0;
			blk_cnt_q   <= '0;
			blk_num_q   <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (restart) begin
			ks_wr_q     <= 1'b0;
			ks_rd_q     <= 1'b0;
			blk_cnt_q   <= '0;
			blk_num_q   <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (launch) begin
				blk_num_q <= blk_num_q + BLKNUM_W'(1);
			end
			if (core_done) begin
				ks_wr_q <= !ks_wr_q;
			end
			if (blk_pop) begin
				ks_rd_q <= !ks_rd_q;
			end
			blk_cnt_q <= blk_cnt_q + KSB_CNT_W'(core_done) - KSB_CNT_W'(blk_pop);
			if (q_pop) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			ks_buf_q[ks_wr_q] <= core_blk;
		end
		if (q_pop) begin
			out_byte_q   <= q_item.data_byte ^ ks_cur[127-8*rd_idx_q -: 8];
			byte_count_q <= q_item.count;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_count = byte_count_q;

	`ASSERT_ALWAYS(a_buf_bound, blk_cnt_q <= KSB_CNT_W'(KSB_DEPTH), "keystream buffer overrun")
	`ASSERT_IMPLY(a_done_has_room, core_done, blk_cnt_q != KSB_CNT_W'(KSB_DEPTH), "block lost")
	`ASSERT_IMPLY(a_idx_match, q_pop, q_item.idx == rd_idx_q, "position out of step")

endmodule

`default_nettype wire

[hdl/aes128_ctr_stream_xor.sv]
// Output: each data word passes the input queue and the output register; out_valid rises
//   once its keystream block is buffered. After reset or a key/nonce write the first block
//   must run through the iterative AES core before a result can appear.
// Throughput: one byte per cycle sustained while out_ready stays high; the iterative AES
//   core fills a two-block keystream buffer ahead of use.
// Reset: arst_n clears key, nonce, position, queues and keystream buffer; cfg_ready is
//   always high and any key or nonce write restarts the stream at position zero.
// ----------------------------------------------------------------------------
// aes128_ctr_stream_xor
// AES-128 counter-mode stream XOR with running byte count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aes128_ctr_stream_xor
	import actr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	// input words
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           data_byte,
	// result words
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_byte,
	output logic [CNT_W-1:0]          byte_count
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [31:0] nonce_high_q;
	logic [63:0] nonce_low_q;
	logic        cfg_wr;
	logic        restart;
	logic        q_valid;
	logic        q_pop;
	item_t       q_item;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Register file. Indexes beyond the list are dropped and do not restart.
	always_comb begin
		restart = 1'b0;
		if (cfg_wr) begin
			case (cfg_index)
				CFG_KEY_HIGH:   restart = 1'b1;
				CFG_KEY_LOW:    restart = 1'b1;
				CFG_NONCE_HIGH: restart = 1'b1;
				CFG_NONCE_LOW:  restart = 1'b1;
				default:        restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q   <= '0;
			key_low_q    <= '0;
			nonce_high_q <= '0;
			nonce_low_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_KEY_HIGH:   key_high_q   <= cfg_data;
				CFG_KEY_LOW:    key_low_q    <= cfg_data;
				CFG_NONCE_HIGH: nonce_high_q <= cfg_data[31:0];
				CFG_NONCE_LOW:  nonce_low_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Front: takes data words and tags each with its stream position.
	actr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// Back: counter blocks through AES, XOR with keystream, output register.
	actr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.key        ({key_high_q, key_low_q}),
		.nonce      ({nonce_high_q, nonce_low_q}),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_count (byte_count)
	);

endmodule

`default_nettype wire

[tb/aes128_ctr_stream_xor_tb.sv]
// ----------------------------------------------------------------------------
// aes128_ctr_stream_xor_tb
// Self-checking bench for the AES-128 CTR byte stream XOR. A directed table
// opens the run from reset (zero key, zero nonce, so the keystream is the well
// known all-zero AES block), then phases rewrite the key and nonce (first
// fixed, then random) and stream random bytes. Each result word is checked
// against hand-typed values (first directed rows) or an in-bench AES-128 CTR
// predictor, with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_ctr_stream_xor_tb;
	import actr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 106;  // 8 phases, ~850 bytes in all
	localparam int IDLE_PCT     = 13;

	// first register index past the list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

	typedef struct {
		logic [7:0]       out_byte;
		logic [CNT_W-1:0] byte_count;
	} xor_word_t;

	// directed row: data byte, and optionally a result typed in by hand
	typedef struct {
		logic [7:0]       data;
		bit               typed;
		logic [7:0]       out_byte;
		logic [CNT_W-1:0] byte_count;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [CNT_W-1:0] byte_count;

	aes128_ctr_stream_xor DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_count (byte_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: key, nonce and stream position
	// ---------------------------------------------------------------------
	logic [63:0]      key_hi, key_lo, nonce_lo;
	logic [31:0]      nonce_hi;
	logic [CNT_W-1:0] stream_pos;

	xor_word_t pending_words[$];
	bit        failed = 1'b0;
	bit        idle_en = 1'b1;     // random idling on both sides
	bit        hold_req = 1'b0;    // asks the receiver for a long hold-off
	int        hold_left = 0;
	int        cycles = 0;

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// plain AES-128 block encryption, round keys derived on the fly
	function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
		input logic [127:0] blk);
		logic [7:0]   st [16];
		logic [7:0]   sh [16];
		logic [127:0] rk;
		logic [31:0]  rot, w0, w1, w2, w3;
		logic [7:0]   rc, a0, a1, a2, a3, sum;
		logic [127:0] res;
		rk = key;
		rc = 8'h01;
		for (int i = 0; i < 16; i++)
			st[i] = blk[127-8*i -: 8] ^ rk[127-8*i -: 8];
		for (int r = 1; r <= 10; r++) begin
			// next round key
			w3  = rk[31:0];
			rot = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
			w0  = rk[127:96] ^ rot;
			w1  = rk[95:64] ^ w0;
			w2  = rk[63:32] ^ w1;
			w3  = w3 ^ w2;
			rk  = {w0, w1, w2, w3};
			rc  = gf_double(rc);
			// substitute and shift rows (column-major state)
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					sh[c*4+i] = SBOX[st[((c+i) % 4)*4+i]];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
					sum = a0 ^ a1 ^ a2 ^ a3;
					sh[c*4]   = a0 ^ sum ^ gf_double(a0 ^ a1);
					sh[c*4+1] = a1 ^ sum ^ gf_double(a1 ^ a2);
					sh[c*4+2] = a2 ^ sum ^ gf_double(a2 ^ a3);
					sh[c*4+3] = a3 ^ sum ^ gf_double(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] = sh[i] ^ rk[127-8*i -: 8];
		end
		for (int i = 0; i < 16; i++)
			res[127-8*i -: 8] = st[i];
		return res;
	endfunction

	// keystream byte for the current position, then advance
	function automatic xor_word_t ctr_xor_byte(input logic [7:0] din);
		logic [127:0] ks;
		xor_word_t    w;
		ks = aes128_encrypt({key_hi, key_lo}, {nonce_hi, nonce_lo, stream_pos[35:4]});
		w.out_byte   = din ^ ks[127-8*stream_pos[3:0] -: 8];
		stream_pos   = stream_pos + 1;
		w.byte_count = stream_pos;
		return w;
	endfunction

	function automatic logic [63:0] pick_reg_value();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		// leave cfg_valid low before returning
		@(posedge clk);
		// any key or nonce write restarts the stream
		case (idx)
			CFG_KEY_HIGH:   begin key_hi = val; stream_pos = '0; end
			CFG_KEY_LOW:    begin key_lo = val; stream_pos = '0; end
			CFG_NONCE_HIGH: begin nonce_hi = val[31:0]; stream_pos = '0; end
			CFG_NONCE_LOW:  begin nonce_lo = val; stream_pos = '0; end
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed,
		input logic [7:0] t_out, input logic [CNT_W-1:0] t_cnt);
		xor_word_t w;
		if (idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		w = ctr_xor_byte(b);
		if (typed) begin
			w.out_byte   = t_out;
			w.byte_count = t_cnt;
		end
		pending_words.push_back(w);
	endtask

	// wait for every word to come back, plus the block's settle time
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
		end
	end

	// result checker
	always @(posedge clk) begin
		xor_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: out_byte %h byte_count %h",
					out_byte, byte_count);
				failed = 1'b1;
			end else begin
				w = pending_words.pop_front();
				if (out_byte !== w.out_byte) begin
					$error("out_byte: expected %h, got %h", w.out_byte, out_byte);
					failed = 1'b1;
				end
				if (byte_count !== w.byte_count) begin
					$error("byte_count: expected %h, got %h", w.byte_count, byte_count);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	dir_row_t dir_rows[$];

	initial begin
		// zero key, zero counter block: keystream starts 66 e9 4b d4
		dir_rows = '{
			'{8'h00, 1'b1, 8'h66, 64'd1},
			'{8'hff, 1'b1, 8'h16, 64'd2},
			'{8'h00, 1'b1, 8'h4b, 64'd3},
			'{8'hff, 1'b1, 8'h2b, 64'd4},
			'{8'h55, 1'b0, 8'h00, 64'd0}, '{8'haa, 1'b0, 8'h00, 64'd0},
			'{8'h01, 1'b0, 8'h00, 64'd0}, '{8'h80, 1'b0, 8'h00, 64'd0},
			'{8'h0f, 1'b0, 8'h00, 64'd0}, '{8'hf0, 1'b0, 8'h00, 64'd0},
			'{8'h00, 1'b0, 8'h00, 64'd0}, '{8'h00, 1'b0, 8'h00, 64'd0},
			'{8'hff, 1'b0, 8'h00, 64'd0}, '{8'hff, 1'b0, 8'h00, 64'd0},
			'{8'h3c, 1'b0, 8'h00, 64'd0}, '{8'hc3, 1'b0, 8'h00, 64'd0},
			// next keystream block begins here
			'{8'h00, 1'b0, 8'h00, 64'd0}, '{8'hff, 1'b0, 8'h00, 64'd0},
			'{8'h7e, 1'b0, 8'h00, 64'd0}, '{8'h81, 1'b0, 8'h00, 64'd0}
		};

		key_hi = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0; stream_pos = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a write past the register list must leave the reset stream alone
		cfg_write(CFG_FIRST_UNUSED, '1);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].typed,
				dir_rows[i].out_byte, dir_rows[i].byte_count);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: for (int r = 0; r < 4; r++) cfg_write(cfg_idx_t'(r), '1);
				1: for (int r = 0; r < 4; r++) cfg_write(cfg_idx_t'(r), '0);
				default: begin
					for (int r = 0; r < 4; r++)
						if ($urandom_range(2) != 0)
							cfg_write(cfg_idx_t'(r), pick_reg_value());
					if ($urandom_range(1))
						cfg_write(CFG_IDX_W'($urandom_range(4, 7)), pick_reg_value());
				end
			endcase
			idle_en = (ph != 3);   // one phase runs flat out on both sides
			if (ph == 2)
				hold_req = 1'b1;   // block fills and back-pressures the input
			for (int n = 0; n < PHASE_BYTES; n++)
				send_byte(8'($urandom_range(255)), 1'b0, '0, '0);
			drain();
		end

		if (!failed)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/actr_pkg.sv
hdl/actr_core.sv
hdl/actr_front.sv
hdl/actr_back.sv
hdl/aes128_ctr_stream_xor.sv
tb/aes128_ctr_stream_xor_tb.sv
